### hw/rtl/dmrr_pkg.sv
// shared types and constants of the dual motor ramp reverser
package dmrr_pkg;

	localparam int DUTY_W  = 7;
	localparam int COUNT_W = 16;
	localparam int RI_W    = 8;
	localparam int TGT_W   = 8;

	localparam logic [DUTY_W-1:0] MAX_DUTY = 7'd100;

	// per-channel sequencer phases
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_RAMP = 3'd1;
	localparam logic [2:0] PH_STOP = 3'd2;
	localparam logic [2:0] PH_FLIP = 3'd3;
	localparam logic [2:0] PH_END  = 3'd4;

	// input word kinds (tuser)
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// configuration register indexes
	localparam logic REG_RAMP_INTERVAL = 1'b0;
	localparam logic REG_STOP_DWELL    = 1'b1;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               rev;
		logic [2:0]         phase;
		logic [COUNT_W-1:0] count;
		logic               up;
		logic [DUTY_W-1:0]  fmag;
	} chan_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} chan_ctrl_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_nxt;
		logic              rev_nxt;
		logic              idle_cur;
		logic              idle_nxt;
	} chan_stat_t;

endpackage

### hw/rtl/dmrr_channel.sv
// one motor channel: command load, ramp / stop / flip sequencer and its state
module dmrr_channel
	import dmrr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  chan_ctrl_t               ctrl,
	input  logic signed [TGT_W-1:0]  target,
	input  logic [COUNT_W-1:0]       stop_dwell,
	output chan_stat_t               stat
);

	chan_state_t st_q;
	chan_state_t pre;
	chan_state_t nxt;
	logic              neg;
	logic [TGT_W-1:0]  mag8;
	logic [DUTY_W-1:0] mag;

	always_comb begin
		pre  = st_q;
		neg  = target[TGT_W-1];
		mag8 = neg ? (TGT_W'(0) - TGT_W'(target)) : TGT_W'(target);
		if (mag8 > {1'b0, MAX_DUTY}) begin
			mag8 = {1'b0, MAX_DUTY};
		end
		mag = mag8[DUTY_W-1:0];

		if (ctrl.load) begin
			pre.fmag = mag;
			if (neg == st_q.rev) begin
				pre.phase = PH_RAMP;
				if (mag >= st_q.duty) begin
					pre.up    = 1'b1;
					pre.count = COUNT_W'(mag - st_q.duty);
				end else begin
					pre.up    = 1'b0;
					pre.count = COUNT_W'(st_q.duty - mag);
				end
			end else begin
				pre.phase = PH_STOP;
				pre.count = (stop_dwell == '0) ? COUNT_W'(1) : stop_dwell;
				pre.up    = 1'b0;
			end
		end

		nxt = pre;
		if (ctrl.step && pre.phase != PH_IDLE) begin
			case (pre.phase)
				PH_RAMP: begin
					if (pre.count != '0) begin
						if (pre.up) begin
							if (pre.duty < MAX_DUTY) nxt.duty = pre.duty + 1'b1;
						end else if (pre.duty != '0) begin
							nxt.duty = pre.duty - 1'b1;
						end
						nxt.count = pre.count - 1'b1;
					end else begin
						nxt.phase = PH_END;
					end
				end
				PH_STOP: begin
					if (pre.count != '0) begin
						nxt.duty  = '0;
						nxt.count = pre.count - 1'b1;
					end else begin
						nxt.phase = PH_FLIP;
						nxt.count = COUNT_W'(1);
					end
				end
				PH_FLIP: begin
					if (pre.count != '0) begin
						nxt.rev   = ~pre.rev;
						nxt.count = pre.count - 1'b1;
					end else begin
						nxt.phase = PH_RAMP;
						nxt.count = COUNT_W'(pre.fmag);
						nxt.up    = 1'b1;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= nxt;
		end
	end

	assign stat.duty_nxt = nxt.duty;
	assign stat.rev_nxt  = nxt.rev;
	assign stat.idle_cur = (st_q.phase == PH_IDLE);
	assign stat.idle_nxt = (nxt.phase == PH_IDLE);

endmodule

### hw/rtl/dual_motor_ramp_reverser_core.sv
// top level of the dual motor ramp reverser: stream ports, prescaler, output register
// an accepted input word passes the input register and then the result register to the master side
// throughput: one word per cycle; the input register and the result register
//   decouple the two sides, so a held result stalls input only once both are full
// reset: arst_n clears both channels to idle, duty 0, forward, prescaler 0,
//   ramp_interval to 2, stop_dwell to 250, and empties both registers
module dual_motor_ramp_reverser_core
	import dmrr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // target_a[7:0], target_b[15:8]
	input  logic [0:0]  s_axis_tuser,   // op[0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // duty_a[6:0], reverse_a[7], duty_b[14:8],
	                                    // reverse_b[15], busy_res[16], zero[23:17]
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [RI_W-1:0]    ramp_interval_q;
	logic [COUNT_W-1:0] stop_dwell_q;

	// input register
	logic                    valid_s1;
	logic                    op_s1;
	logic signed [TGT_W-1:0] tgt_a_s1;
	logic signed [TGT_W-1:0] tgt_b_s1;

	// result register
	logic        out_valid_q;
	logic [23:0] out_data_q;

	// shared tick prescaler
	logic [RI_W-1:0] prescale_q;
	logic [RI_W-1:0] prescale_inc;
	logic [RI_W-1:0] prescale_nxt;
	logic [RI_W-1:0] lim;

	logic       adv;
	logic       cmd;
	logic       busy_cur;
	logic       busy_nxt;
	logic       hit;
	chan_ctrl_t ctrl;
	chan_stat_t stat_a;
	chan_stat_t stat_b;

	// the input register moves on when the result register is free or being emptied
	assign adv           = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | adv;

	assign cmd      = (op_s1 == OP_CMD);
	assign busy_cur = ~(stat_a.idle_cur & stat_b.idle_cur);
	assign busy_nxt = ~(stat_a.idle_nxt & stat_b.idle_nxt);

	// a zero interval behaves as one
	assign lim          = (ramp_interval_q == '0) ? RI_W'(1) : ramp_interval_q;
	assign prescale_inc = prescale_q + 1'b1;
	assign hit          = (prescale_inc >= lim);

	// a command is taken only while idle and makes the first step at once;
	// a tick steps both channels once the prescaler reaches the interval
	always_comb begin
		ctrl.load = adv & cmd & ~busy_cur;
		ctrl.step = ctrl.load | (adv & ~cmd & busy_cur & hit);
	end

	always_comb begin
		prescale_nxt = prescale_q;
		if (ctrl.load) begin
			prescale_nxt = '0;
		end else if (!cmd && busy_cur) begin
			prescale_nxt = hit ? '0 : prescale_inc;
		end
		// prescaler rests at zero whenever nothing runs
		if (!busy_nxt) begin
			prescale_nxt = '0;
		end
	end

	dmrr_channel u_chan_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.target     (tgt_a_s1),
		.stop_dwell (stop_dwell_q),
		.stat       (stat_a)
	);

	dmrr_channel u_chan_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.target     (tgt_b_s1),
		.stop_dwell (stop_dwell_q),
		.stat       (stat_b)
	);

	// configuration port: write it only while the block is idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_interval_q <= RI_W'(2);
			stop_dwell_q    <= COUNT_W'(250);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_INTERVAL: ramp_interval_q <= cfg_data[RI_W-1:0];
				REG_STOP_DWELL:    stop_dwell_q    <= cfg_data;
				default:           ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1    <= s_axis_tuser[0];
			tgt_a_s1 <= s_axis_tdata[7:0];
			tgt_b_s1 <= s_axis_tdata[15:8];
		end
	end

	// prescaler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
		end else if (adv) begin
			prescale_q <= prescale_nxt;
		end
	end

	// result register: the state after each word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {7'd0, busy_nxt, stat_b.rev_nxt, stat_b.duty_nxt,
			               stat_a.rev_nxt, stat_a.duty_nxt};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/dmrr_checker.sv
// port-level checks of the dual motor ramp reverser and their bind
module dmrr_checker
	import dmrr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// duty never exceeds the limit
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] <= MAX_DUTY && m_axis_tdata[14:8] <= MAX_DUTY)
		else $error("duty above limit");

	// input is never stalled while the result side takes words
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled with free result side");

	// a fresh result word follows an accepted input word, through the input and the result register
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result word without input word");

endmodule

bind dual_motor_ramp_reverser_core dmrr_checker u_dmrr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### test/dual_motor_ramp_reverser_core_tb.sv
// self-checking testbench of the dual motor ramp reverser core
module dual_motor_ramp_reverser_core_tb;
	import dmrr_pkg::*;

	// run limit in clock cycles, far above the slowest correct run
	localparam int CYCLE_LIMIT = 1000000;
	// idle cycles after the last result before a register write or the end
	localparam int SETTLE_CYCLES = 6;

	// golden model of both channels plus the queue of result words still owed
	class motor_scoreboard;
		bit [7:0]    ramp_interval = 8'd2;
		bit [15:0]   stop_dwell    = 16'd250;
		bit [6:0]    duty[2];
		bit          rev[2];
		bit [2:0]    ph[2];
		bit [15:0]   cnt[2];
		bit          up[2];
		bit [6:0]    fmag[2];
		bit [7:0]    prescale;
		logic [23:0] owed_q[$];
		int          errors;

		function new();
			for (int c = 0; c < 2; c++) begin
				duty[c] = '0;
				rev[c]  = 1'b0;
				ph[c]   = PH_IDLE;
				cnt[c]  = '0;
				up[c]   = 1'b0;
				fmag[c] = '0;
			end
			prescale = '0;
			errors   = 0;
		endfunction

		function bit running();
			return ph[0] != PH_IDLE || ph[1] != PH_IDLE;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void set_reg(logic idx, logic [15:0] val);
			if (idx == REG_RAMP_INTERVAL)
				ramp_interval = val[7:0];
			else
				stop_dwell = val;
		endfunction

		// take a new signed target for one channel
		function void load_target(int c, logic [7:0] raw);
			int mag;
			bit neg;
			neg = raw[7];
			mag = neg ? 256 - int'(raw) : int'(raw);
			if (mag > int'(MAX_DUTY))
				mag = int'(MAX_DUTY);
			fmag[c] = mag[6:0];
			if (neg == rev[c]) begin
				// same direction, plain ramp
				ph[c] = PH_RAMP;
				up[c] = mag >= int'(duty[c]);
				cnt[c] = 16'(up[c] ? mag - int'(duty[c]) : int'(duty[c]) - mag);
			end else begin
				// reversal, stop first
				ph[c]  = PH_STOP;
				cnt[c] = (stop_dwell == 0) ? 16'd1 : stop_dwell;
				up[c]  = 1'b0;
			end
		endfunction

		function void advance_channel(int c);
			case (ph[c])
				PH_RAMP: begin
					if (cnt[c] != 0) begin
						if (up[c]) begin
							if (duty[c] < MAX_DUTY)
								duty[c] = duty[c] + 7'd1;
						end else if (duty[c] != 0) begin
							duty[c] = duty[c] - 7'd1;
						end
						cnt[c] = cnt[c] - 16'd1;
					end else begin
						ph[c] = PH_END;
					end
				end
				PH_STOP: begin
					if (cnt[c] != 0) begin
						duty[c] = '0;
						cnt[c]  = cnt[c] - 16'd1;
					end else begin
						ph[c]  = PH_FLIP;
						cnt[c] = 16'd1;
					end
				end
				PH_FLIP: begin
					if (cnt[c] != 0) begin
						rev[c] = ~rev[c];
						cnt[c] = cnt[c] - 16'd1;
					end else begin
						ph[c]  = PH_RAMP;
						cnt[c] = {9'd0, fmag[c]};
						up[c]  = 1'b1;
					end
				end
				default: ph[c] = PH_IDLE;
			endcase
		endfunction

		function void advance_both();
			for (int c = 0; c < 2; c++)
				if (ph[c] != PH_IDLE)
					advance_channel(c);
		endfunction

		// an input word was accepted: update the model and owe one result word
		function void note_word(logic op, logic [7:0] ta, logic [7:0] tb);
			int lim;
			if (op == OP_CMD) begin
				if (!running()) begin
					load_target(0, ta);
					load_target(1, tb);
					prescale = '0;
					advance_both();
				end
			end else if (running()) begin
				lim = (ramp_interval == 0) ? 1 : int'(ramp_interval);
				prescale = prescale + 8'd1;
				if (int'(prescale) >= lim) begin
					prescale = '0;
					advance_both();
				end
			end
			if (!running())
				prescale = '0;
			owed_q.push_back({7'd0, running(), rev[1], duty[1], rev[0], duty[0]});
		endfunction

		function void report(string what, logic [23:0] want, logic [23:0] got);
			errors++;
			if (errors <= 10) begin
				$display("%s: exp duty_a=%0d rev_a=%0d duty_b=%0d rev_b=%0d busy=%0d pad=%h",
					what, want[6:0], want[7], want[14:8], want[15], want[16], want[23:17]);
				$display("  got duty_a=%0d rev_a=%0d duty_b=%0d rev_b=%0d busy=%0d pad=%h",
					got[6:0], got[7], got[14:8], got[15], got[16], got[23:17]);
			end
		endfunction

		// a result word was accepted: compare it with the oldest owed word
		function void check_result(logic [23:0] got);
			logic [23:0] want;
			if (owed_q.size() == 0) begin
				report("unexpected word", 'x, got);
				return;
			end
			want = owed_q.pop_front();
			if (got[6:0] !== want[6:0] || got[7] !== want[7] || got[14:8] !== want[14:8] ||
				got[15] !== want[15] || got[16] !== want[16] || got[23:17] !== want[23:17])
				report("word mismatch", want, got);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;     // target_a[7:0], target_b[15:8]
	logic [0:0]  s_axis_tuser = '0;     // op[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;          // duty_a[6:0], reverse_a[7], duty_b[14:8],
	                                    // reverse_b[15], busy_res[16], zero[23:17]
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	motor_scoreboard sb = new();

	int cycle_count = 0;
	int rx_cycle = 0;
	int burst_left = 1;

	dual_motor_ramp_reverser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 2 time unit clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_motor_ramp_reverser_core_tb failed");
			$finish;
		end
	end

	// result side: check accepted words, stall in a pattern chosen by bits 9:8 of the cycle counter
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[9:8])
			2'd0: m_axis_tready <= 1'b1;                           // never stall
			2'd1: m_axis_tready <= $urandom_range(0, 3) != 0;      // light random stalls
			2'd2: m_axis_tready <= (rx_cycle % 7) < 3;             // periodic stalls
			default: m_axis_tready <= $urandom_range(0, 3) == 0;   // heavy stalls, backs up input
		endcase
	end

	// one input word; the sender runs in bursts with random gaps in between
	task automatic send_word(input logic op, input logic [7:0] ta, input logic [7:0] tb);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tb, ta};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_word(op, ta, tb);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// tick with junk in the target fields
	task automatic send_tick();
		send_word(OP_TICK, 8'($urandom), 8'($urandom));
	endtask

	// tick until the model says both channels are done
	task automatic settle();
		while (sb.running())
			send_tick();
	endtask

	// stop sending, wait for every owed word, then a short pause
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, only once drained
	task automatic configure(input logic [7:0] ri, input logic [15:0] sd);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_RAMP_INTERVAL;
		cfg_data  <= {8'd0, ri};
		@(posedge clk);
		cfg_index <= REG_STOP_DWELL;
		cfg_data  <= sd;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(REG_RAMP_INTERVAL, {8'd0, ri});
		sb.set_reg(REG_STOP_DWELL, sd);
	endtask

	// random target; keep_rev 0 or 1 forces that direction, -1 leaves it free
	function automatic logic [7:0] pick_target(input bit small_mag, input int keep_rev);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (small_mag || r < 45)
			v = int'($urandom_range(0, 20)) - 10;
		else if (r < 85)
			v = int'($urandom_range(0, 200)) - 100;
		else
			v = int'($urandom_range(0, 255)) - 128;
		if (keep_rev == 0 && v < 0)
			v = (v == -128) ? 127 : -v;
		if (keep_rev == 1 && v >= 0)
			v = (v == 0) ? -1 : -v;
		return v[7:0];
	endfunction

	// mostly commands while idle and ticks while busy; some commands while busy
	// and ticks while idle as noise; a running sequence carries over into the next phase
	task automatic run_phase(input logic [7:0] ri, input logic [15:0] sd, input int n,
		input bit small_mag, input bit keep_dir);
		int done_n;
		int r;
		configure(ri, sd);
		done_n = 0;
		while (done_n < n) begin
			r = $urandom_range(0, 99);
			if (!sb.running()) begin
				if (r < 90) begin
					send_word(OP_CMD,
						pick_target(small_mag, keep_dir ? int'(sb.rev[0]) : -1),
						pick_target(small_mag, keep_dir ? int'(sb.rev[1]) : -1));
					done_n++;
				end else begin
					send_tick();
				end
			end else if (r < 4) begin
				// ignored while the sequence runs; never reverses under the long dwell
				send_word(OP_CMD, pick_target(small_mag, keep_dir ? int'(sb.rev[0]) : -1),
					pick_target(small_mag, keep_dir ? int'(sb.rev[1]) : -1));
			end else begin
				send_tick();
				done_n++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, reset register values first
		send_tick();                               // tick while idle
		send_word(OP_CMD, 8'sd2, 8'sd1);           // plain ramps up
		settle();
		send_word(OP_CMD, 8'sd1, 8'sd0);           // both ramp down by one
		settle();

		configure(8'd1, 16'd1);
		send_word(OP_CMD, -8'sd3, 8'sd0);          // a reverses
		send_word(OP_CMD, 8'sd50, 8'sd50);         // command while busy, ignored
		settle();
		send_word(OP_CMD, 8'sd127, -8'sd128);      // both clamped, both reverse
		settle();
		send_word(OP_CMD, -8'sd100, 8'sd100);      // full reversal at the limits
		settle();
		send_word(OP_CMD, 8'sd0, 8'sd0);           // zero counts as forward
		settle();

		configure(8'd0, 16'd0);                    // zero interval and zero dwell
		send_word(OP_CMD, -8'sd1, -8'sd5);
		settle();
		send_word(OP_CMD, 8'sd4, 8'sd1);
		settle();

		// random part over several settings
		run_phase(8'd1,   16'd1,     110, 1'b0, 1'b0);
		run_phase(8'd0,   16'd3,     80,  1'b0, 1'b0);
		run_phase(8'd3,   16'd2,     70,  1'b0, 1'b0);
		run_phase(8'd255, 16'd1,     260, 1'b1, 1'b0);  // slowest interval, short ramps
		run_phase(8'd2,   16'd0,     70,  1'b0, 1'b0);
		run_phase(8'd1,   16'd65535, 50,  1'b0, 1'b1);  // longest dwell, same direction only
		run_phase(8'd1,   16'd4,     50,  1'b0, 1'b0);

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("dual_motor_ramp_reverser_core_tb passed");
		end else begin
			$display("dual_motor_ramp_reverser_core_tb failed");
		end
		$finish;
	end

endmodule
